[rtl/core/ini_line_tokenizer_defines.svh]
// Assertion macros for the INI line tokenizer
`ifndef INI_LINE_TOKENIZER_DEFINES_SVH
`define INI_LINE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define ILT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ILT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ILT_ASSERT(label, clk, rst_n, prop)
`define ILT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/ilt_pkg.sv]
// Shared types and constants of the INI line tokenizer
package ilt_pkg;
    localparam int unsigned MaxDocBytes = 65536;
    localparam int unsigned CfgW = 17;

    localparam logic [2:0] CFG_DOC     = 3'd0;
    localparam logic [2:0] CFG_LINE    = 3'd1;
    localparam logic [2:0] CFG_SECTION = 3'd2;
    localparam logic [2:0] CFG_KEY     = 3'd3;
    localparam logic [2:0] CFG_VALUE   = 3'd4;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_ENTRY   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] name_offset;
        logic [15:0] name_length;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        done;
        logic [1:0]  status;
    } rec_t;

    function automatic logic is_name_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2d || c == 8'h2e;
    endfunction
endpackage

[rtl/core/ilt_front.sv]
// Byte scanner: classifies bytes, tracks line state, forms records
module ilt_front #(
    parameter int unsigned MAX_DOC_BYTES = ilt_pkg::MaxDocBytes,
    parameter int unsigned PW = $clog2(MAX_DOC_BYTES + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    input  logic                 last_byte,
    input  logic [ilt_pkg::CfgW-1:0] doc_limit,
    input  logic [ilt_pkg::CfgW-1:0] line_limit,
    input  logic [ilt_pkg::CfgW-1:0] section_limit,
    input  logic [ilt_pkg::CfgW-1:0] key_limit,
    input  logic [ilt_pkg::CfgW-1:0] value_limit,
    output logic                 rec_valid,
    output ilt_pkg::rec_t        rec
);
    import ilt_pkg::*;

    localparam logic [PW-1:0] MaxP = PW'(MAX_DOC_BYTES);
    localparam int unsigned XW = (PW > CfgW) ? PW : CfgW;

    localparam logic [1:0] CLS_EMPTY = 2'd0;
    localparam logic [1:0] CLS_SKIP = 2'd1;
    localparam logic [1:0] CLS_SECTION = 2'd2;
    localparam logic [1:0] CLS_ENTRY = 2'd3;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] lstart_reg;
    logic [PW-1:0] first_reg, first_next, last_reg, last_next, eq_reg, eq_next;
    logic [PW-1:0] vfirst_reg, vfirst_next, vlast_reg, vlast_next;
    logic [1:0] cls_reg, cls_next;
    logic gap_reg, gap_next, bad_reg, bad_next, eqf_reg, eqf_next, seen_reg, seen_next;
    logic gl_reg, gl_next, lb_reg, lb_next, lc_reg, lc_next;
    logic cr_reg, cr_next, cerr_reg, cerr_next;
    logic [1:0] lerr_reg;

    logic [XW-1:0] eff;
    logic in_doc, close_line, close_cr, over, pinner, nb;
    logic [PW-1:0] end_pos, p1;
    logic [XW-1:0] raw, span, ssize, klen, vlen;
    logic [1:0] ekind, eerr;
    logic [PW-1:0] voff;
    logic [1:0] status;

    assign eff = (XW'(doc_limit) < XW'(MAX_DOC_BYTES)) ? XW'(doc_limit) : XW'(MAX_DOC_BYTES);
    assign in_doc = XW'(pos_reg) < eff;
    assign p1 = pos_reg + PW'(1);
    assign nb = is_name_byte(byte_in);
    assign pinner = last_reg != first_reg;

    always_comb
    begin
        pos_next = (pos_reg <= MaxP) ? p1 : pos_reg;
        first_next = first_reg; last_next = last_reg; eq_next = eq_reg;
        vfirst_next = vfirst_reg; vlast_next = vlast_reg; cls_next = cls_reg;
        gap_next = gap_reg; bad_next = bad_reg; eqf_next = eqf_reg; seen_next = seen_reg;
        gl_next = gl_reg; lb_next = lb_reg; lc_next = lc_reg;
        cr_next = cr_reg; cerr_next = cerr_reg;
        close_line = 1'b0; close_cr = 1'b0; end_pos = pos_reg;
        if (in_doc)
        begin
            if (cr_reg && byte_in != 8'h0a) cerr_next = 1'b1;
            cr_next = 1'b0;
            if (byte_in == 8'h00 || byte_in == 8'h7f ||
                (byte_in < 8'h20 && byte_in != 8'h0a && byte_in != 8'h0d && byte_in != 8'h09))
                cerr_next = 1'b1;
            if (byte_in == 8'h0a)
            begin
                close_line = 1'b1; close_cr = cr_reg; end_pos = pos_reg;
            end
            else if (byte_in == 8'h0d)
            begin
                cr_next = 1'b1;
                if (last_byte) cerr_next = 1'b1;
            end
            else
            begin
                gap_next = 1'b0;
                if (byte_in == 8'h20 || byte_in == 8'h09)
                    gap_next = 1'b1;
                else if (cls_reg == CLS_EMPTY)
                begin
                    first_next = pos_reg; last_next = pos_reg;
                    if (byte_in == 8'h23 || byte_in == 8'h3b) cls_next = CLS_SKIP;
                    else if (byte_in == 8'h5b) cls_next = CLS_SECTION;
                    else
                    begin
                        cls_next = CLS_ENTRY;
                        if (byte_in == 8'h3d)
                        begin
                            eqf_next = 1'b1; eq_next = pos_reg;
                        end
                        else if (!nb) bad_next = 1'b1;
                    end
                end
                else if (cls_reg == CLS_SECTION)
                begin
                    if (pinner && (lb_reg || gl_reg)) bad_next = 1'b1;
                    gl_next = gap_reg && pinner;
                    lb_next = !nb;
                    lc_next = byte_in == 8'h5d;
                    vlast_next = last_reg;
                    last_next = pos_reg;
                    if (!seen_reg)
                    begin
                        vfirst_next = pos_reg; seen_next = 1'b1;
                    end
                end
                else if (cls_reg == CLS_ENTRY)
                begin
                    if (!eqf_reg)
                    begin
                        if (byte_in == 8'h3d)
                        begin
                            eqf_next = 1'b1; eq_next = pos_reg;
                        end
                        else
                        begin
                            if (gap_reg || !nb) bad_next = 1'b1;
                            last_next = pos_reg;
                        end
                    end
                    else
                    begin
                        if (!seen_reg)
                        begin
                            vfirst_next = pos_reg; seen_next = 1'b1;
                        end
                        vlast_next = pos_reg;
                    end
                end
            end
            if (last_byte && byte_in != 8'h0a)
            begin
                close_line = 1'b1; close_cr = cr_next; end_pos = p1;
            end
        end
    end

    // line close evaluation uses the updated line state
    always_comb
    begin
        raw = XW'(end_pos - lstart_reg);
        if (close_cr && raw != '0) raw = raw - XW'(1);
        span = XW'(last_next - first_next) + XW'(1);
        ssize = (vlast_next != first_next) ? XW'(vlast_next - vfirst_next) + XW'(1) : '0;
        klen = (eq_next != first_next) ? XW'(last_next - first_next) + XW'(1) : '0;
        vlen = seen_next ? XW'(vlast_next - vfirst_next) + XW'(1) : '0;
        voff = seen_next ? vfirst_next : eq_next + PW'(1);
        ekind = KIND_NONE; eerr = ST_OK;
        if (raw > XW'(line_limit)) eerr = ST_LIMIT;
        else if (cls_next == CLS_SECTION)
        begin
            if (span < XW'(3) || !lc_next) eerr = ST_FORMAT;
            else if (ssize > XW'(section_limit)) eerr = ST_LIMIT;
            else if (ssize == '0 || bad_next) eerr = ST_FORMAT;
            else ekind = KIND_SECTION;
        end
        else if (cls_next == CLS_ENTRY)
        begin
            if (!eqf_next) eerr = ST_FORMAT;
            else if (klen > XW'(key_limit) || vlen > XW'(value_limit)) eerr = ST_LIMIT;
            else if (klen == '0 || bad_next) eerr = ST_FORMAT;
            else ekind = KIND_ENTRY;
        end
        if (!close_line)
        begin
            ekind = KIND_NONE; eerr = ST_OK;
        end
    end

    logic [1:0] lerr_new;
    assign lerr_new = (lerr_reg != ST_OK) ? lerr_reg : eerr;
    assign over = XW'(pos_next) > eff;
    assign status = over ? ST_LIMIT : (cerr_next ? ST_FORMAT : lerr_new);

    always_comb
    begin
        rec_valid = step && (last_byte ||
            (ekind != KIND_NONE && !over && !cerr_next && lerr_new == ST_OK));
        rec.kind = (last_byte && status != ST_OK) ? KIND_NONE : ekind;
        rec.name_offset = 16'((ekind == KIND_SECTION) ? vfirst_next : first_next);
        rec.name_length = 16'((ekind == KIND_SECTION) ? ssize : klen);
        rec.value_offset = (ekind == KIND_ENTRY) ? 16'(voff) : 16'd0;
        rec.value_length = (ekind == KIND_ENTRY) ? 16'(vlen) : 16'd0;
        if (rec.kind == KIND_NONE)
        begin
            rec.name_offset = '0; rec.name_length = '0;
            rec.value_offset = '0; rec.value_length = '0;
        end
        rec.done = last_byte;
        rec.status = last_byte ? status : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; lstart_reg <= '0; first_reg <= '0; last_reg <= '0;
            eq_reg <= '0; vfirst_reg <= '0; vlast_reg <= '0; cls_reg <= CLS_EMPTY;
            gap_reg <= 1'b0; bad_reg <= 1'b0; eqf_reg <= 1'b0; seen_reg <= 1'b0;
            gl_reg <= 1'b0; lb_reg <= 1'b0; lc_reg <= 1'b0;
            cr_reg <= 1'b0; cerr_reg <= 1'b0; lerr_reg <= ST_OK;
        end
        else if (step)
        begin
            if (last_byte || (close_line && byte_in == 8'h0a))
            begin
                first_reg <= '0; last_reg <= '0; eq_reg <= '0; vfirst_reg <= '0;
                vlast_reg <= '0; cls_reg <= CLS_EMPTY; gap_reg <= 1'b0; bad_reg <= 1'b0;
                eqf_reg <= 1'b0; seen_reg <= 1'b0; gl_reg <= 1'b0; lb_reg <= 1'b0;
                lc_reg <= 1'b0;
            end
            else
            begin
                first_reg <= first_next; last_reg <= last_next; eq_reg <= eq_next;
                vfirst_reg <= vfirst_next; vlast_reg <= vlast_next; cls_reg <= cls_next;
                gap_reg <= gap_next; bad_reg <= bad_next; eqf_reg <= eqf_next;
                seen_reg <= seen_next; gl_reg <= gl_next; lb_reg <= lb_next;
                lc_reg <= lc_next;
            end
            if (last_byte)
            begin
                pos_reg <= '0; lstart_reg <= '0; cr_reg <= 1'b0;
                cerr_reg <= 1'b0; lerr_reg <= ST_OK;
            end
            else
            begin
                pos_reg <= pos_next; cr_reg <= cr_next; cerr_reg <= cerr_next;
                lerr_reg <= lerr_new;
                lstart_reg <= (close_line && byte_in == 8'h0a) ? p1 : lstart_reg;
            end
        end
    end
endmodule

[rtl/core/ilt_queue.sv]
// Two-entry record queue between the scanner and the output port
module ilt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ilt_pkg::rec_t din,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output ilt_pkg::rec_t dout
);
    import ilt_pkg::*;

    `include "ini_line_tokenizer_defines.svh"

    rec_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic pop;

    assign pop = out_valid && out_ready;
    assign out_valid = cnt_reg != 2'd0;
    assign full = cnt_reg == 2'd2;
    assign dout = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    `ILT_NEVER(a_no_overflow, clk, rst_n, push && full)
    `ILT_NEVER(a_count_range, clk, rst_n, cnt_reg == 2'd3)
    `ILT_ASSERT(a_count_track, clk, rst_n, (push && !pop && !full) |=> cnt_reg != 2'd0)
endmodule

[rtl/core/ini_line_tokenizer.sv]
// Top level of the INI line tokenizer
// Takes one document byte per clock when the record queue has room and emits a
// record at the end of each good section or entry line, plus a status record on
// the last byte. Each record is registered in the record queue; throughput is one
// byte per cycle, set by the scanner, while out_ready keeps up.
module ini_line_tokenizer #(
    parameter int unsigned MAX_DOC_BYTES = ilt_pkg::MaxDocBytes
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  record_kind,
    output logic [15:0] name_offset,
    output logic [15:0] name_length,
    output logic [15:0] value_offset,
    output logic [15:0] value_length,
    output logic        doc_done,
    output logic [1:0]  doc_status
);
    import ilt_pkg::*;

    logic [CfgW-1:0] doc_reg, line_reg, sec_reg, key_reg, val_reg;
    logic full, step, rv;
    rec_t rec, q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doc_reg <= 17'd65536; line_reg <= 17'd1024; sec_reg <= 17'd64;
            key_reg <= 17'd64; val_reg <= 17'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DOC:     doc_reg <= cfg_data;
                CFG_LINE:    line_reg <= cfg_data;
                CFG_SECTION: sec_reg <= cfg_data;
                CFG_KEY:     key_reg <= cfg_data;
                CFG_VALUE:   val_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign in_ready = !full;
    assign step = in_valid && in_ready;

    ilt_front #(.MAX_DOC_BYTES(MAX_DOC_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .byte_in(byte_in), .last_byte(last_byte),
        .doc_limit(doc_reg), .line_limit(line_reg), .section_limit(sec_reg),
        .key_limit(key_reg), .value_limit(val_reg), .rec_valid(rv), .rec(rec)
    );

    ilt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(rv), .din(rec), .full(full),
        .out_valid(out_valid), .out_ready(out_ready), .dout(q)
    );

    assign record_kind = q.kind;
    assign name_offset = q.name_offset;
    assign name_length = q.name_length;
    assign value_offset = q.value_offset;
    assign value_length = q.value_length;
    assign doc_done = q.done;
    assign doc_status = q.status;
endmodule

[bench/ilt_checker.sv]
// Checker of the INI line tokenizer: predicts each record from the accepted bytes and compares
module ilt_checker
    import ilt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  record_kind,
    input  logic [15:0] name_offset,
    input  logic [15:0] name_length,
    input  logic [15:0] value_offset,
    input  logic [15:0] value_length,
    input  logic        doc_done,
    input  logic [1:0]  doc_status,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {LN_EMPTY, LN_SKIP, LN_SECTION, LN_ENTRY} line_kind_e;

    localparam int F_GAP = 0;
    localparam int F_BAD = 1;
    localparam int F_EQ = 2;
    localparam int F_SEEN = 3;
    localparam int F_GAP_LAST = 4;
    localparam int F_LAST_BAD = 5;
    localparam int F_LAST_CLOSE = 6;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_EQ = 8'h3d;
    localparam logic [7:0] CH_OPEN = 8'h5b;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_DEL = 8'h7f;

    logic [16:0] lim_doc, lim_line, lim_section, lim_key, lim_value;
    logic [16:0] byte_count, line_begin, text_first, text_last, eq_at, val_first, val_last;
    line_kind_e  line_kind;
    logic [7:0]  flags;
    logic        cr_waiting, bad_byte;
    logic [1:0]  line_err;

    rec_t record_fifo[$];

    assign pending = record_fifo.size();

    function automatic bit name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2d || c == 8'h2e;
    endfunction

    function void note_error(input logic [1:0] code);
        if (line_err == ST_OK)
            line_err = code;
    endfunction

    function void clear_line();
        text_first = '0;
        text_last = '0;
        eq_at = '0;
        val_first = '0;
        val_last = '0;
        line_kind = LN_EMPTY;
        flags = '0;
    endfunction

    function void clear_doc();
        byte_count = '0;
        line_begin = '0;
        cr_waiting = 1'b0;
        bad_byte = 1'b0;
        line_err = ST_OK;
        clear_line();
    endfunction

    function void scan_text(input logic [7:0] c, input logic [16:0] q);
        bit gap;
        bit inner;
        gap = flags[F_GAP];
        flags[F_GAP] = 1'b0;
        if (c == CH_SPACE || c == CH_TAB)
        begin
            flags[F_GAP] = 1'b1;
            return;
        end
        case (line_kind)
            LN_EMPTY:
            begin
                text_first = q;
                text_last = q;
                if (c == CH_HASH || c == CH_SEMI)
                    line_kind = LN_SKIP;
                else if (c == CH_OPEN)
                    line_kind = LN_SECTION;
                else
                begin
                    line_kind = LN_ENTRY;
                    if (c == CH_EQ)
                    begin
                        flags[F_EQ] = 1'b1;
                        eq_at = q;
                    end
                    else if (!name_char(c))
                        flags[F_BAD] = 1'b1;
                end
            end
            LN_SECTION:
            begin
                inner = text_last != text_first;
                if (inner && (flags[F_LAST_BAD] || flags[F_GAP_LAST]))
                    flags[F_BAD] = 1'b1;
                flags[F_GAP_LAST] = 1'b0;
                flags[F_LAST_BAD] = 1'b0;
                flags[F_LAST_CLOSE] = 1'b0;
                if (gap && inner)
                    flags[F_GAP_LAST] = 1'b1;
                if (!name_char(c))
                    flags[F_LAST_BAD] = 1'b1;
                if (c == CH_CLOSE)
                    flags[F_LAST_CLOSE] = 1'b1;
                val_last = text_last;
                text_last = q;
                if (!flags[F_SEEN])
                begin
                    val_first = q;
                    flags[F_SEEN] = 1'b1;
                end
            end
            LN_ENTRY:
            begin
                if (!flags[F_EQ])
                begin
                    if (c == CH_EQ)
                    begin
                        flags[F_EQ] = 1'b1;
                        eq_at = q;
                    end
                    else
                    begin
                        if (gap || !name_char(c))
                            flags[F_BAD] = 1'b1;
                        text_last = q;
                    end
                end
                else
                begin
                    if (!flags[F_SEEN])
                    begin
                        val_first = q;
                        flags[F_SEEN] = 1'b1;
                    end
                    val_last = q;
                end
            end
            default: ;
        endcase
    endfunction

    function logic [1:0] close_line(input int unsigned end_pos, input bit cr, inout rec_t r);
        int unsigned raw;
        int unsigned span;
        int unsigned size;
        int unsigned klen;
        int unsigned vlen;
        int unsigned voff;
        raw = end_pos - line_begin;
        if (cr && raw > 0)
            raw--;
        if (raw > lim_line)
        begin
            note_error(ST_LIMIT);
            return KIND_NONE;
        end
        if (line_kind == LN_SECTION)
        begin
            span = text_last - text_first + 1;
            size = 0;
            if (span < 3 || !flags[F_LAST_CLOSE])
            begin
                note_error(ST_FORMAT);
                return KIND_NONE;
            end
            if (val_last != text_first)
                size = val_last - val_first + 1;
            if (size > lim_section)
            begin
                note_error(ST_LIMIT);
                return KIND_NONE;
            end
            if (size == 0 || flags[F_BAD])
            begin
                note_error(ST_FORMAT);
                return KIND_NONE;
            end
            r.name_offset = val_first[15:0];
            r.name_length = size[15:0];
            return KIND_SECTION;
        end
        if (line_kind == LN_ENTRY)
        begin
            klen = 0;
            vlen = 0;
            voff = eq_at + 1;
            if (!flags[F_EQ])
            begin
                note_error(ST_FORMAT);
                return KIND_NONE;
            end
            if (eq_at != text_first)
                klen = text_last - text_first + 1;
            if (flags[F_SEEN])
            begin
                voff = val_first;
                vlen = val_last - val_first + 1;
            end
            if (klen > lim_key || vlen > lim_value)
            begin
                note_error(ST_LIMIT);
                return KIND_NONE;
            end
            if (klen == 0 || flags[F_BAD])
            begin
                note_error(ST_FORMAT);
                return KIND_NONE;
            end
            r.name_offset = text_first[15:0];
            r.name_length = klen[15:0];
            r.value_offset = voff[15:0];
            r.value_length = vlen[15:0];
            return KIND_ENTRY;
        end
        return KIND_NONE;
    endfunction

    function bit tokenize_byte(input logic [7:0] b, input bit last, output rec_t r);
        int unsigned eff;
        int unsigned p;
        bit cr;
        bit over;
        logic [1:0] kind;
        logic [1:0] status;
        r = '0;
        kind = KIND_NONE;
        status = ST_OK;
        eff = (lim_doc < MaxDocBytes) ? lim_doc : MaxDocBytes;
        p = byte_count;
        if (p < eff)
        begin
            cr = cr_waiting;
            if (cr_waiting && b != CH_LF)
                bad_byte = 1'b1;
            cr_waiting = 1'b0;
            if (b == 8'h00 || b == CH_DEL ||
                (b < CH_SPACE && b != CH_LF && b != CH_CR && b != CH_TAB))
                bad_byte = 1'b1;
            if (b == CH_LF)
            begin
                kind = close_line(p, cr, r);
                line_begin = p + 1;
                clear_line();
            end
            else if (b == CH_CR)
            begin
                cr_waiting = 1'b1;
                if (last)
                    bad_byte = 1'b1;
            end
            else
                scan_text(b, p[16:0]);
            if (last && b != CH_LF)
                kind = close_line(p + 1, cr_waiting, r);
        end
        if (byte_count < MaxDocBytes + 1)
            byte_count++;
        over = byte_count > eff;
        if (last)
        begin
            if (over)
                status = ST_LIMIT;
            else if (bad_byte)
                status = ST_FORMAT;
            else
                status = line_err;
            clear_doc();
            if (status != ST_OK)
                kind = KIND_NONE;
        end
        else if (kind == KIND_NONE || over || bad_byte || line_err != ST_OK)
            return 1'b0;
        if (kind == KIND_NONE)
            r = '0;
        else if (kind == KIND_SECTION)
        begin
            r.value_offset = '0;
            r.value_length = '0;
        end
        r.kind = kind;
        r.done = last;
        r.status = status;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rec_t exp_rec;
        rec_t got;
        if (!rst_n)
        begin
            lim_doc <= 17'd65536;
            lim_line <= 17'd1024;
            lim_section <= 17'd64;
            lim_key <= 17'd64;
            lim_value <= 17'd512;
            clear_doc();
            record_fifo.delete();
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{record_kind, name_offset, name_length, value_offset, value_length,
                        doc_done, doc_status};
                if (record_fifo.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected record %p", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_rec = record_fifo.pop_front();
                    if (got !== exp_rec)
                    begin
                        if (mismatches < 10)
                            $display("record mismatch: expected %p, actual %p", exp_rec, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                if (tokenize_byte(byte_in, last_byte, exp_rec))
                    record_fifo.push_back(exp_rec);
            if (cfg_we)
                case (cfg_index)
                    CFG_DOC: lim_doc <= cfg_data;
                    CFG_LINE: lim_line <= cfg_data;
                    CFG_SECTION: lim_section <= cfg_data;
                    CFG_KEY: lim_key <= cfg_data;
                    CFG_VALUE: lim_value <= cfg_data;
                    default: ;
                endcase
        end
    end
endmodule

[bench/tb_ini_line_tokenizer.sv]
// Testbench top of the INI line tokenizer: document stimulus, handshake idling and verdict
module tb_ini_line_tokenizer;
    import ilt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = '0;
    logic        last_byte = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_DOC;
    logic [16:0] cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  record_kind;
    logic [15:0] name_offset, name_length, value_offset, value_length;
    logic        doc_done;
    logic [1:0]  doc_status;
    int          mismatches;
    int          pending;
    int          bytes_sent = 0;
    bit          calm = 1'b0;

    logic [7:0] doc_bytes[$];

    localparam string NAME_SET = "abzAZ09_.-mQ";

    ini_line_tokenizer u_dut (.*);

    ilt_checker u_chk (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb_ini_line_tokenizer failed");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    initial
    begin
        int g;
        forever
        begin
            g = draw_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic push_str(input string s);
        foreach (s[i]) doc_bytes.push_back(s[i]);
    endtask

    task automatic push_pad();
        repeat ($urandom_range(0, 2))
            doc_bytes.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endtask

    task automatic push_name(input int len);
        repeat (len)
            if ($urandom_range(0, 30) == 0)
                doc_bytes.push_back(8'($urandom_range(33, 255)));
            else
                doc_bytes.push_back(NAME_SET[$urandom_range(0, NAME_SET.len() - 1)]);
    endtask

    task automatic push_text(input int len);
        repeat (len)
            case ($urandom_range(0, 5))
                0: doc_bytes.push_back(8'($urandom_range(128, 255)));
                1: doc_bytes.push_back(8'h20);
                default: doc_bytes.push_back(8'($urandom_range(33, 126)));
            endcase
    endtask

    task automatic push_eol();
        case ($urandom_range(0, 9))
            0, 1, 2: push_str("\r\n");
            3: if ($urandom_range(0, 3) == 0) doc_bytes.push_back(8'h0d);
            default: push_str("\n");
        endcase
    endtask

    task automatic build_doc();
        doc_bytes.delete();
        repeat ($urandom_range(1, 6))
        begin
            push_pad();
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    push_str("[");
                    push_pad();
                    push_name($urandom_range(0, 6));
                    push_pad();
                    if ($urandom_range(0, 7) != 0) push_str("]");
                end
                3, 4, 5, 6:
                begin
                    push_name($urandom_range(0, 6));
                    push_pad();
                    if ($urandom_range(0, 7) != 0) push_str("=");
                    push_pad();
                    push_text($urandom_range(0, 8));
                end
                7: begin push_str($urandom_range(0, 1) ? "#" : ";"); push_text($urandom_range(0, 6)); end
                8: ;
                default: push_text($urandom_range(0, 10));
            endcase
            push_pad();
            push_eol();
        end
        if ($urandom_range(0, 2) == 0 && doc_bytes.size() > 1)
            void'(doc_bytes.pop_back());
        if ($urandom_range(0, 7) == 0)
            doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic send_doc();
        int g;
        calm = ($urandom_range(0, 4) == 0);
        foreach (doc_bytes[i])
        begin
            in_valid <= 1'b1;
            byte_in <= doc_bytes[i];
            last_byte <= (i == doc_bytes.size() - 1);
            do @(posedge clk); while (!(in_valid && in_ready));
            bytes_sent++;
            g = draw_gap();
            if (g > 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    function automatic logic [16:0] pick_limit(input int typical);
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(1, 8));
            default: return 17'(typical);
        endcase
    endfunction

    task automatic one_doc(input string s);
        doc_bytes.delete();
        push_str(s);
        send_doc();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        one_doc("[s]\r\n k = v\n#c\n");
        one_doc("[]\n=x");
        one_doc("a\rb");
        doc_bytes.delete();
        doc_bytes.push_back(8'h00);
        send_doc();
        one_doc({"k=", 8'hff, 8'h7f, 8'h0d});
        drain();
        write_reg(CFG_DOC, 17'd3);
        write_reg(CFG_LINE, 17'd0);
        cfg_we <= 1'b0;
        one_doc("a=b\n");
        drain();
        write_reg(CFG_DOC, 17'd65536);
        write_reg(CFG_LINE, 17'd1024);
        write_reg(CFG_SECTION, 17'd1);
        write_reg(CFG_KEY, 17'd1);
        write_reg(CFG_VALUE, 17'd0);
        cfg_we <= 1'b0;
        one_doc("[ab]\nab=\n");
        while (bytes_sent < 1000)
        begin
            drain();
            write_reg(CFG_DOC, ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 60)) :
                               pick_limit(65536));
            write_reg(CFG_LINE, pick_limit(1024));
            write_reg(CFG_SECTION, pick_limit(64));
            write_reg(CFG_KEY, pick_limit(64));
            write_reg(CFG_VALUE, pick_limit(512));
            cfg_we <= 1'b0;
            repeat ($urandom_range(2, 6))
            begin
                build_doc();
                send_doc();
            end
        end
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_ini_line_tokenizer passed");
        else
            $display("tb_ini_line_tokenizer failed");
        $finish;
    end
endmodule

[ini_line_tokenizer.f]
+incdir+rtl/core
rtl/core/ilt_pkg.sv
rtl/core/ilt_front.sv
rtl/core/ilt_queue.sv
rtl/core/ini_line_tokenizer.sv
bench/ilt_checker.sv
bench/tb_ini_line_tokenizer.sv
